// File: rtl/core/best_fit_partition_allocator_macros.svh
// Assertion macros used by the allocator's top-level RTL.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bfpa_pkg.sv
`default_nettype none

package bfpa_pkg;

   // Default sizes of the partition table.
   localparam int unsigned DEF_NUM_PARTITIONS = 8;
   localparam int unsigned DEF_ADDR_BITS      = 16;

   // Fixed widths of the beat fields.
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned INDEX_W  = 3;
   localparam int unsigned FIELD_W  = 16;
   localparam int unsigned OWNER_W  = 4;
   localparam int unsigned STATUS_W = 2;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_DEFINE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_BIG   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the accepted request and restart the scan
      logic scan;    // step the table scan
      logic commit;  // update the table and load the result register
   } bfpa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_scan;   // the offered request needs a table scan
      logic scan_last;  // the last table entry is being evaluated
   } bfpa_sts_type;

endpackage

`default_nettype wire

// File: rtl/core/bfpa_datapath.sv
`default_nettype none

module bfpa_datapath import bfpa_pkg::*; #(
   parameter int unsigned NUM_PARTITIONS = DEF_NUM_PARTITIONS,
   parameter int unsigned ADDR_BITS      = DEF_ADDR_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bfpa_cmd_type        cmd,
   output bfpa_sts_type             sts,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [INDEX_W-1:0]  req_entry_index,
   input  wire logic [FIELD_W-1:0]  req_entry_base,
   input  wire logic [FIELD_W-1:0]  req_length_value,
   input  wire logic [OWNER_W-1:0]  req_owner_id,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [INDEX_W-1:0]       rsp_chosen_index,
   output logic [FIELD_W-1:0]       rsp_chosen_base,
   output logic [FIELD_W-1:0]       rsp_chosen_length
);

   localparam int unsigned IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int unsigned CNT_W = $clog2(NUM_PARTITIONS + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_PARTITIONS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTITIONS - 1);

   // Partition table: base, length and owner in memory; valid and taken in flops.
   logic [ADDR_BITS-1:0] mem_base  [NUM_PARTITIONS];
   logic [ADDR_BITS-1:0] mem_len   [NUM_PARTITIONS];
   logic [OWNER_W-1:0]   mem_owner [NUM_PARTITIONS];
   logic [NUM_PARTITIONS-1:0] valid_ff, valid_in;
   logic [NUM_PARTITIONS-1:0] taken_ff, taken_in;

   // Captured request.
   logic [FUNC_W-1:0]    func_ff;
   logic                 def_ok_ff;
   logic [IDX_W-1:0]     def_idx_ff;
   logic [ADDR_BITS-1:0] req_base_ff;
   logic [ADDR_BITS-1:0] req_len_ff;
   logic [OWNER_W-1:0]   req_owner_ff;

   // Scan state.
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [ADDR_BITS-1:0] rd_base_ff;
   logic [ADDR_BITS-1:0] rd_len_ff;
   logic [OWNER_W-1:0]   rd_owner_ff;

   // Running choice of the scan.
   logic                 hit_ff, hit_in;
   logic                 fits_ff, fits_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [ADDR_BITS-1:0] best_base_ff, best_base_in;
   logic [ADDR_BITS-1:0] best_len_ff, best_len_in;

   // Entry under evaluation.
   logic                 ent_vld;
   logic                 ent_taken;
   logic [ADDR_BITS-1:0] ent_len;
   logic [OWNER_W-1:0]   ent_owner;
   logic                 ent_fit;

   // Table write port.
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ADDR_BITS-1:0] wr_base;
   logic [ADDR_BITS-1:0] wr_len;
   logic [OWNER_W-1:0]   wr_owner;

   // Result register.
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [FIELD_W-1:0]   rsp_base_ff, rsp_base_in;
   logic [FIELD_W-1:0]   rsp_len_ff, rsp_len_in;

   // Status toward the controller.
   assign sts.req_scan  = (req_func == FUNC_ALLOC) || (req_func == FUNC_RELEASE);
   assign sts.scan_last = rd_vld_ff && (rd_idx_ff == LAST_IDX);

   // Capture the request beat, keeping base and length to the address width.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff      <= req_func;
         def_ok_ff    <= 32'(req_entry_index) < NUM_PARTITIONS;
         def_idx_ff   <= IDX_W'(req_entry_index);
         req_base_ff  <= ADDR_BITS'(req_entry_base);
         req_len_ff   <= ADDR_BITS'(req_length_value);
         req_owner_ff <= req_owner_id;
      end
   end

   // One table read is issued per scan cycle until every entry has been read.
   assign rd_en   = cmd.scan && (scan_ff != SCAN_END);
   assign rd_addr = scan_ff[IDX_W-1:0];

   // An entry that was never defined reads as unused, free and owned by zero.
   assign ent_vld   = valid_ff[rd_idx_ff];
   assign ent_taken = taken_ff[rd_idx_ff];
   assign ent_len   = ent_vld ? rd_len_ff : '0;
   assign ent_owner = ent_vld ? rd_owner_ff : '0;
   assign ent_fit   = (ent_len != '0) && (ent_len >= req_len_ff);

   // Scan counter and running best-fit or first-owner choice.
   always_comb begin
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      fits_in      = fits_ff;
      best_idx_in  = best_idx_ff;
      best_base_in = best_base_ff;
      best_len_in  = best_len_ff;
      if (cmd.load) begin
         scan_in = '0;
         hit_in  = 1'b0;
         fits_in = 1'b0;
      end else if (cmd.scan) begin
         if (rd_en) begin
            scan_in = scan_ff + CNT_W'(1);
         end
         if (rd_vld_ff) begin
            if (func_ff == FUNC_ALLOC) begin
               // Strictly smaller length wins, so the lowest index keeps ties.
               if (ent_fit) begin
                  fits_in = 1'b1;
               end
               if (ent_fit && !ent_taken && (!hit_ff || (ent_len < best_len_ff))) begin
                  hit_in       = 1'b1;
                  best_idx_in  = rd_idx_ff;
                  best_base_in = rd_base_ff;
                  best_len_in  = ent_len;
               end
            end else begin
               // Release keeps the first taken entry held by the owner.
               if (!hit_ff && ent_taken && (ent_owner == req_owner_ff)) begin
                  hit_in       = 1'b1;
                  best_idx_in  = rd_idx_ff;
                  best_base_in = rd_base_ff;
                  best_len_in  = ent_len;
               end
            end
         end
      end
   end

   // Table write: define writes the whole entry, allocate records the owner.
   assign wr_en = cmd.commit && (((func_ff == FUNC_DEFINE) && def_ok_ff) ||
                                 ((func_ff == FUNC_ALLOC) && hit_ff));
   assign wr_addr  = (func_ff == FUNC_DEFINE) ? def_idx_ff  : best_idx_ff;
   assign wr_base  = (func_ff == FUNC_DEFINE) ? req_base_ff : best_base_ff;
   assign wr_len   = (func_ff == FUNC_DEFINE) ? req_len_ff  : best_len_ff;
   assign wr_owner = (func_ff == FUNC_DEFINE) ? '0          : req_owner_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_base[wr_addr]  <= wr_base;
         mem_len[wr_addr]   <= wr_len;
         mem_owner[wr_addr] <= wr_owner;
      end
      if (rd_en) begin
         rd_base_ff  <= mem_base[rd_addr];
         rd_len_ff   <= mem_len[rd_addr];
         rd_owner_ff <= mem_owner[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
   end

   // Valid and taken bits change only at commit or reset.
   always_comb begin
      valid_in = valid_ff;
      taken_in = taken_ff;
      if (cmd.commit) begin
         case (func_ff)
            FUNC_DEFINE: begin
               if (def_ok_ff) begin
                  valid_in[def_idx_ff] = 1'b1;
                  taken_in[def_idx_ff] = 1'b0;
               end
            end
            FUNC_ALLOC: begin
               if (hit_ff) begin
                  taken_in[best_idx_ff] = 1'b1;
               end
            end
            FUNC_RELEASE: begin
               if (hit_ff) begin
                  taken_in[best_idx_ff] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result beat; every error and the unknown operation give zero fields.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_len_in    = rsp_len_ff;
      if (cmd.commit) begin
         rsp_status_in = STATUS_OK;
         rsp_index_in  = '0;
         rsp_base_in   = '0;
         rsp_len_in    = '0;
         case (func_ff)
            FUNC_DEFINE: begin
               if (def_ok_ff) begin
                  rsp_index_in = INDEX_W'(def_idx_ff);
                  rsp_base_in  = FIELD_W'(req_base_ff);
                  rsp_len_in   = FIELD_W'(req_len_ff);
               end
            end
            FUNC_ALLOC: begin
               if (hit_ff) begin
                  rsp_index_in = INDEX_W'(best_idx_ff);
                  rsp_base_in  = FIELD_W'(best_base_ff);
                  rsp_len_in   = FIELD_W'(best_len_ff);
               end else if (fits_ff) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_status_in = STATUS_TOO_BIG;
               end
            end
            FUNC_RELEASE: begin
               if (hit_ff) begin
                  rsp_index_in = INDEX_W'(best_idx_ff);
                  rsp_base_in  = FIELD_W'(best_base_ff);
                  rsp_len_in   = FIELD_W'(best_len_ff);
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         taken_ff  <= '0;
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         fits_ff   <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         taken_ff  <= taken_in;
         scan_ff   <= scan_in;
         rd_vld_ff <= rd_en;
         hit_ff    <= hit_in;
         fits_ff   <= fits_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_base_ff  <= best_base_in;
      best_len_ff   <= best_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_chosen_index  = rsp_index_ff;
   assign rsp_chosen_base   = rsp_base_ff;
   assign rsp_chosen_length = rsp_len_ff;

endmodule

`default_nettype wire

// File: rtl/core/bfpa_ctrl.sv
`default_nettype none

module bfpa_ctrl import bfpa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire bfpa_sts_type sts,
   output bfpa_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencing: capture, optional table scan, then commit into the result register.
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = sts.req_scan ? ST_SCAN : ST_RESP;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result beat stays valid until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/best_fit_partition_allocator.sv
// Channel   Direction  Handshake             Fields
// req       in         req_valid/req_ready   func, entry_index, entry_base, length_value, owner_id
// rsp       out        rsp_valid/rsp_ready   status, chosen_index, chosen_base, chosen_length
//
// Define and unknown operations skip the table scan and go from capture straight to commit.
// Allocate and release scan the table one entry per cycle through its single read
// port, and then commit their result beat like the other operations.
// Reset clears every partition to unused and free.
// A new beat is accepted while an earlier result beat still waits; a stalled result
// holds the next operation in its commit step.
`default_nettype none

`include "best_fit_partition_allocator_macros.svh"

module best_fit_partition_allocator import bfpa_pkg::*; #(
   parameter int unsigned NUM_PARTITIONS = DEF_NUM_PARTITIONS,
   parameter int unsigned ADDR_BITS      = DEF_ADDR_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [INDEX_W-1:0]  req_entry_index,
   input  wire logic [FIELD_W-1:0]  req_entry_base,
   input  wire logic [FIELD_W-1:0]  req_length_value,
   input  wire logic [OWNER_W-1:0]  req_owner_id,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [INDEX_W-1:0]       rsp_chosen_index,
   output logic [FIELD_W-1:0]       rsp_chosen_base,
   output logic [FIELD_W-1:0]       rsp_chosen_length
);

   bfpa_cmd_type cmd;
   bfpa_sts_type sts;

   // Sequencer.
   bfpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Partition table and scan datapath.
   bfpa_datapath #(
      .NUM_PARTITIONS (NUM_PARTITIONS),
      .ADDR_BITS      (ADDR_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_entry_base    (req_entry_base),
      .req_length_value  (req_length_value),
      .req_owner_id      (req_owner_id),
      .rsp_status        (rsp_status),
      .rsp_chosen_index  (rsp_chosen_index),
      .rsp_chosen_base   (rsp_chosen_base),
      .rsp_chosen_length (rsp_chosen_length)
   );

   // Only one operation is in flight, so ready drops right after a request beat.
   `BFPA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready,
                     "request accepted while busy")

   // An error result carries zero index, base and length.
   `BFPA_ASSERT_NOW(a_error_fields_zero, clock, reset,
                    rsp_valid && (rsp_status != STATUS_OK),
                    (rsp_chosen_index == '0) && (rsp_chosen_base == '0) &&
                    (rsp_chosen_length == '0),
                    "error result with nonzero fields")

   // A commit never overwrites a result beat that is still waiting.
   `BFPA_ASSERT_NOW(a_commit_has_room, clock, reset, cmd.commit, !rsp_valid || rsp_ready,
                    "commit over a pending result")

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench import bfpa_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PART     = DEF_NUM_PARTITIONS;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_ITEMS = 425;
   localparam int PRESSURE_AT  = 200;

   // The package names no code for the fourth operation value.
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] entry_index;
      logic [FIELD_W-1:0] entry_base;
      logic [FIELD_W-1:0] length_value;
      logic [OWNER_W-1:0] owner_id;
   } part_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [FIELD_W-1:0]  base;
      logic [FIELD_W-1:0]  length;
   } part_result_type;

   typedef struct packed {
      part_request_type req;
      bit               has_result;
      part_result_type  result;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [FUNC_W-1:0]  req_func         = '0;
   logic [INDEX_W-1:0] req_entry_index  = '0;
   logic [FIELD_W-1:0] req_entry_base   = '0;
   logic [FIELD_W-1:0] req_length_value = '0;
   logic [OWNER_W-1:0] req_owner_id     = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_chosen_index;
   logic [FIELD_W-1:0]  rsp_chosen_base;
   logic [FIELD_W-1:0]  rsp_chosen_length;

   // Shadow copy of the partition table.
   logic [FIELD_W-1:0] shadow_base   [NUM_PART];
   logic [FIELD_W-1:0] shadow_length [NUM_PART];
   logic [OWNER_W-1:0] shadow_owner  [NUM_PART];
   logic               shadow_taken  [NUM_PART];

   part_result_type  pending_results[$];
   directed_row_type directed_rows[$];

   bit          no_idle = 1'b0;
   int unsigned error_count = 0;
   int unsigned n_define = 0, n_granted = 0, n_full = 0, n_too_big = 0;
   int unsigned n_freed = 0, n_missing = 0, n_unknown = 0;

   best_fit_partition_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_entry_base    (req_entry_base),
      .req_length_value  (req_length_value),
      .req_owner_id      (req_owner_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_chosen_index  (rsp_chosen_index),
      .rsp_chosen_base   (rsp_chosen_base),
      .rsp_chosen_length (rsp_chosen_length)
   );

   always #5 clock = ~clock;

   // Applies one operation to the shadow table and returns the result beat it should give.
   function automatic part_result_type apply_partition_op(input part_request_type r);
      part_result_type res;
      bit              fits_any;
      bit              found;
      int              best;
      res      = '0;
      fits_any = 1'b0;
      found    = 1'b0;
      best     = 0;
      case (r.func)
         FUNC_DEFINE: begin
            n_define++;
            if (r.entry_index < NUM_PART) begin
               shadow_base[r.entry_index]   = r.entry_base;
               shadow_length[r.entry_index] = r.length_value;
               shadow_owner[r.entry_index]  = '0;
               shadow_taken[r.entry_index]  = 1'b0;
               res.index  = r.entry_index;
               res.base   = r.entry_base;
               res.length = r.length_value;
            end
         end
         FUNC_ALLOC: begin
            // Best fit: smallest free entry that covers the request, lowest index on a tie.
            for (int i = 0; i < NUM_PART; i++) begin
               if (shadow_length[i] != 0 && shadow_length[i] >= r.length_value) begin
                  fits_any = 1'b1;
                  if (!shadow_taken[i] && (!found || shadow_length[i] < shadow_length[best])) begin
                     found = 1'b1;
                     best  = i;
                  end
               end
            end
            if (found) begin
               shadow_taken[best] = 1'b1;
               shadow_owner[best] = r.owner_id;
               res.index  = best[INDEX_W-1:0];
               res.base   = shadow_base[best];
               res.length = shadow_length[best];
               n_granted++;
            end else if (fits_any) begin
               res.status = STATUS_FULL;
               n_full++;
            end else begin
               res.status = STATUS_TOO_BIG;
               n_too_big++;
            end
         end
         FUNC_RELEASE: begin
            // Only the lowest-indexed entry held by the owner is freed.
            for (int i = 0; i < NUM_PART; i++) begin
               if (!found && shadow_taken[i] && shadow_owner[i] == r.owner_id) begin
                  found           = 1'b1;
                  shadow_taken[i] = 1'b0;
                  res.index  = i[INDEX_W-1:0];
                  res.base   = shadow_base[i];
                  res.length = shadow_length[i];
               end
            end
            if (found) begin
               n_freed++;
            end else begin
               res.status = STATUS_NOT_FOUND;
               n_missing++;
            end
         end
         default: begin
            n_unknown++;
         end
      endcase
      return res;
   endfunction

   function automatic void add_row(input logic [FUNC_W-1:0] func, input int idx, input int base,
                                   input int len, input int owner, input bit has_result = 1'b0,
                                   input logic [STATUS_W-1:0] st = STATUS_OK, input int ix = 0,
                                   input int b = 0, input int l = 0);
      directed_row_type row;
      row.req        = '{func, idx[INDEX_W-1:0], base[FIELD_W-1:0], len[FIELD_W-1:0],
                         owner[OWNER_W-1:0]};
      row.has_result = has_result;
      row.result     = '{st, ix[INDEX_W-1:0], b[FIELD_W-1:0], l[FIELD_W-1:0]};
      directed_rows.push_back(row);
   endfunction

   // Sizes cluster near the defined lengths so that allocations often fit, with some extremes.
   function automatic logic [FIELD_W-1:0] pick_size();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return FIELD_W'($urandom);
      else if (sel == 1)
         return '0;
      else
         return FIELD_W'($urandom_range(1, 64));
   endfunction

   function automatic part_request_type random_request();
      part_request_type r;
      int unsigned      sel;
      r.func         = FUNC_UNKNOWN;
      r.entry_index  = INDEX_W'($urandom);
      r.entry_base   = FIELD_W'($urandom);
      r.length_value = FIELD_W'($urandom);
      r.owner_id     = OWNER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, 3));
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         r.func         = FUNC_DEFINE;
         r.length_value = pick_size();
      end else if (sel < 60) begin
         r.func         = FUNC_ALLOC;
         r.length_value = pick_size();
      end else if (sel < 95) begin
         r.func = FUNC_RELEASE;
      end
      return r;
   endfunction

   // Offers one request beat and records its expected result once it is taken.
   task automatic send_request(input part_request_type r, input bit has_result,
                               input part_result_type typed);
      int unsigned     gap;
      part_result_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= r.func;
      req_entry_index  <= r.entry_index;
      req_entry_base   <= r.entry_base;
      req_length_value <= r.length_value;
      req_owner_id     <= r.owner_id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_partition_op(r);
      pending_results.push_back(has_result ? typed : predicted);
   endtask

   // Result side: a random stall before each beat, none while in a no-idle stretch.
   initial begin
      int unsigned stall;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Compare every result beat against the oldest expectation.
   always @(posedge clock) begin : result_check
      part_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no request outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_chosen_index !== want.index) begin
               $error("chosen_index: expected %0d, got %0d", want.index, rsp_chosen_index);
               error_count++;
            end
            if (rsp_chosen_base !== want.base) begin
               $error("chosen_base: expected 0x%04h, got 0x%04h", want.base, rsp_chosen_base);
               error_count++;
            end
            if (rsp_chosen_length !== want.length) begin
               $error("chosen_length: expected 0x%04h, got 0x%04h", want.length,
                      rsp_chosen_length);
               error_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      part_request_type r;
      for (int i = 0; i < NUM_PART; i++) begin
         shadow_base[i]   = '0;
         shadow_length[i] = '0;
         shadow_owner[i]  = '0;
         shadow_taken[i]  = 1'b0;
      end

      // Empty table, then the extremes of every field.
      add_row(FUNC_ALLOC,   0, 'hFFFF, 1, 1, 1, STATUS_TOO_BIG);
      add_row(FUNC_ALLOC,   7, 0, 0, 2, 1, STATUS_TOO_BIG);
      add_row(FUNC_RELEASE, 0, 0, 0, 0, 1, STATUS_NOT_FOUND);
      add_row(FUNC_UNKNOWN, 7, 'hFFFF, 'hFFFF, 15, 1, STATUS_OK);
      add_row(FUNC_DEFINE,  0, 0, 'hFFFF, 0, 1, STATUS_OK, 0, 0, 'hFFFF);
      add_row(FUNC_DEFINE,  7, 'hFFFF, 1, 15, 1, STATUS_OK, 7, 'hFFFF, 1);
      add_row(FUNC_DEFINE,  3, 'h1234, 100, 0, 1, STATUS_OK, 3, 'h1234, 100);
      add_row(FUNC_DEFINE,  5, 'h5678, 100, 0, 1, STATUS_OK, 5, 'h5678, 100);
      add_row(FUNC_DEFINE,  1, 'hAAAA, 'h5555, 0, 1, STATUS_OK, 1, 'hAAAA, 'h5555);
      add_row(FUNC_DEFINE,  2, 'h5555, 'hAAAA, 0, 1, STATUS_OK, 2, 'h5555, 'hAAAA);
      // Best fit with a zero request, then a tie between two equal lengths.
      add_row(FUNC_ALLOC,   0, 0, 0, 15);
      add_row(FUNC_ALLOC,   0, 0, 100, 15);
      add_row(FUNC_ALLOC,   0, 0, 100, 0);
      add_row(FUNC_ALLOC,   0, 0, 'hFFFF, 9);
      add_row(FUNC_ALLOC,   0, 0, 'hFFFF, 9, 1, STATUS_FULL);
      add_row(FUNC_ALLOC,   0, 0, 'h5555, 0);
      // Releases go lowest index first until the owner holds nothing.
      add_row(FUNC_RELEASE, 0, 0, 0, 15);
      add_row(FUNC_RELEASE, 0, 0, 0, 15);
      add_row(FUNC_RELEASE, 0, 0, 0, 15, 1, STATUS_NOT_FOUND);
      // Redefining a taken entry frees it and clears its owner.
      add_row(FUNC_DEFINE,  5, 'h0F0F, 0, 0, 1, STATUS_OK, 5, 'h0F0F, 0);
      add_row(FUNC_RELEASE, 0, 0, 0, 0);
      add_row(FUNC_RELEASE, 0, 0, 0, 0);
      add_row(FUNC_ALLOC,   0, 0, 'hFFFF, 3);
      add_row(FUNC_RELEASE, 0, 0, 0, 9);
      add_row(FUNC_UNKNOWN, 0, 0, 0, 0, 1, STATUS_OK);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].has_result,
                      directed_rows[i].result);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         // Once, let the block drain completely before going on.
         if (n == PRESSURE_AT) begin
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         r = random_request();
         send_request(r, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * NUM_PART) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end

      $display("Covered %0d defines, %0d allocations (%0d granted, %0d full, %0d too big),",
               n_define, n_granted + n_full + n_too_big, n_granted, n_full, n_too_big);
      $display("%0d releases (%0d freed, %0d with no holder) and %0d unknown operations.",
               n_freed + n_missing, n_freed, n_missing, n_unknown);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
